/* hw/rtl/lse_pkg.sv */
// Package for the LIFO stack engine: sizes, request and status codes,
// controller states and the command struct. Depends on nothing.
package lse_pkg;

  localparam int DEPTH      = 1024;
  localparam int ELEM_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int POS_BITS   = 11;
  localparam int DATA_BITS  = 32;

  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_TOP     = 3'd2,
    REQ_PEEK    = 3'd3,
    REQ_INDEX   = 3'd4,
    REQ_DISCARD = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_DISCARD  = 2'd3
  } status_t;

  // Source of the read data shown with a result.
  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_MEM  = 2'd1,
    RD_DATA = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // evaluate the request, access memory, update the count
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

/* hw/rtl/lse_ctrl.sv */
// Controller of the LIFO stack engine: the request sequencing state machine.
// Depends on lse_pkg.
module lse_ctrl
  import lse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        // A new item may be taken while the result is on the ports.
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      S_RESP: begin
        cmd.load = start;
        done     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  a_exec_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done)
    else $error("result strobe did not follow evaluation");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without an evaluated item");

  a_never_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("stack reported full and empty at once");

endmodule

/* hw/rtl/lse_datapath.sv */
// Datapath of the LIFO stack engine: request registers, element count,
// stack memory and result registers. Depends on lse_pkg.
module lse_datapath
  import lse_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  input  logic [2:0]                  req_type,
  input  logic                        write_data,
  input  logic signed [DATA_BITS-1:0] data,
  input  logic [POS_BITS-1:0]         position,
  output logic [1:0]                  status,
  output logic signed [DATA_BITS-1:0] read_data,
  output logic [COUNT_BITS-1:0]       count
);

  logic [ELEM_BITS-1:0]  mem [DEPTH];
  logic [ELEM_BITS-1:0]  mem_q;

  logic [2:0]            req_r;
  logic                  wr_r;
  logic [DATA_BITS-1:0]  data_r;
  logic [POS_BITS-1:0]   pos_r;

  logic [COUNT_BITS-1:0] count_next;
  status_t               status_r;
  status_t               status_next;
  rd_sel_t               rd_sel;
  rd_sel_t               rd_sel_next;
  logic [ADDR_BITS-1:0]  addr;
  logic                  mem_we;
  logic                  mem_re;

  logic [COUNT_BITS-1:0] count_dec;
  logic [COUNT_BITS:0]   pos_ext;
  logic [COUNT_BITS:0]   count_ext;
  logic                  pos_in_range;
  logic                  pos_fits;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      wr_r   <= write_data;
      data_r <= data;
      pos_r  <= position;
    end
  end

  assign count_dec    = count - COUNT_BITS'(1);
  assign pos_ext      = (COUNT_BITS + 1)'(pos_r);
  assign count_ext    = (COUNT_BITS + 1)'(count);
  assign pos_in_range = pos_ext < count_ext;
  assign pos_fits     = pos_ext <= count_ext;
  assign stat.full    = count == COUNT_BITS'(DEPTH);
  assign stat.empty   = count == '0;

  always_comb begin
    status_next = ST_MISS;
    rd_sel_next = RD_ZERO;
    count_next  = count;
    addr        = count_dec[ADDR_BITS-1:0];
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unique case (req_r)
      REQ_PUSH: begin
        addr = count[ADDR_BITS-1:0];
        if (stat.full) begin
          status_next = ST_OVERFLOW;
        end else begin
          status_next = ST_OK;
          count_next  = count + COUNT_BITS'(1);
          mem_we      = wr_r;
          mem_re      = !wr_r;
          rd_sel_next = wr_r ? RD_DATA : RD_MEM;
        end
      end
      REQ_POP: begin
        if (!stat.empty) begin
          status_next = ST_OK;
          count_next  = count_dec;
          mem_re      = 1'b1;
          rd_sel_next = RD_MEM;
        end
      end
      REQ_TOP: begin
        if (!stat.empty) begin
          status_next = ST_OK;
          mem_re      = 1'b1;
          rd_sel_next = RD_MEM;
        end
      end
      REQ_PEEK: begin
        addr = count_dec[ADDR_BITS-1:0] - pos_r[ADDR_BITS-1:0];
        if (pos_in_range) begin
          status_next = ST_OK;
          mem_re      = 1'b1;
          rd_sel_next = RD_MEM;
        end
      end
      REQ_INDEX: begin
        addr = pos_r[ADDR_BITS-1:0];
        if (pos_in_range) begin
          status_next = ST_OK;
          mem_re      = 1'b1;
          rd_sel_next = RD_MEM;
        end
      end
      REQ_DISCARD: begin
        if (pos_fits) begin
          status_next = ST_OK;
          count_next  = COUNT_BITS'(count_ext - pos_ext);
        end else begin
          status_next = ST_DISCARD;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[addr] <= data_r[ELEM_BITS-1:0];
    end
    if (cmd.exec && mem_re) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_next;
      rd_sel   <= rd_sel_next;
    end
  end

  assign status = status_r;

  always_comb begin
    unique case (rd_sel)
      RD_MEM:  read_data = mem_q[DATA_BITS-1:0];
      RD_DATA: read_data = data_r;
      default: read_data = '0;
    endcase
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("element count above depth");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count))
    else $error("element count changed outside evaluation");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && mem_we) |-> (!stat.full && addr == count[ADDR_BITS-1:0]))
    else $error("memory write outside the free slot");

endmodule

/* hw/rtl/lifo_stack_engine.sv */
// Top level of the LIFO stack engine: joins controller and datapath.
// Depends on lse_pkg, lse_ctrl and lse_datapath.
//
// Usage: drive req_type, write_data, data and position and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// Requests are push (optionally writing data), pop, top, peek at an offset
// below the top, read by absolute index, and discard a number of elements.
// Each item gives exactly one result: status, read_data and count are valid
// while done is high, which lasts one cycle; the receiver cannot hold it off.
// Latency: the item is evaluated in the cycle after it is taken (one stack
// memory access and the count update), and done is high in the cycle after
// that. A new item may be taken in the same cycle as done, so the block
// sustains one item every two cycles, set by the registered memory read.
// Failed requests leave the count and memory unchanged.
// Reset (rst, synchronous) empties the stack; memory contents are not
// cleared, and a slot reserved by a push without data reads as unknown.
module lifo_stack_engine
  import lse_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic                        write_data,
  input  logic signed [DATA_BITS-1:0] data,
  input  logic [POS_BITS-1:0]         position,
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [DATA_BITS-1:0] read_data,
  output logic [COUNT_BITS-1:0]       count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lse_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .write_data (write_data),
    .data       (data),
    .position   (position),
    .status     (status),
    .read_data  (read_data),
    .count      (count)
  );

endmodule
